>>> rtl/time_indexed_log_directory_macros.svh
// ============================================================================
// Assertion macros for the time indexed log directory
// Shared shorthands for clocked assertions with a synchronous active-low reset.
// ============================================================================
`ifndef TIME_INDEXED_LOG_DIRECTORY_MACROS_SVH
`define TIME_INDEXED_LOG_DIRECTORY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tld_pkg.sv
// ============================================================================
// tld_pkg
// Widths, codes and controller/datapath interface types of the log directory.
// ============================================================================
package tld_pkg;

    localparam int TC_W   = 64;
    localparam int POS_W  = 40;
    localparam int CNT_W  = 48;
    localparam int STEP_W = 32;
    localparam int REQ_W  = 2;
    localparam int STS_W  = 2;

    localparam int DIR_ENTRIES_DEF = 256;
    localparam int FRAME_BYTES_DEF = 64;

    localparam logic [POS_W-1:0] BASE_RESET = 40'd4096;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SYNC   = 2'd2;

    // Result status codes.
    localparam logic [STS_W-1:0] ST_APPENDED = 2'd0;
    localparam logic [STS_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STS_W-1:0] ST_LOOKUP   = 2'd2;
    localparam logic [STS_W-1:0] ST_SYNCED   = 2'd3;

    typedef struct packed {
        logic load_item;
        logic do_append;
        logic do_sync;
        logic srch_init;
        logic srch_step;
        logic idx_zero;
        logic idx_clamp;
        logic walk_dec;
        logic rd_copy;
        logic pos_take;
        logic rem_step;
        logic cp_wr;
        logic cp_end;
        logic out_load;
        logic out_round;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             out_free;
        logic             srch_trivial;
        logic             srch_stop;
        logic             idx_zero;
        logic             tc_lt_t;
        logic             pos_zero_more;
        logic             rem_done;
        logic             compact;
        logic             cp_last;
    } t_sts;

endpackage

>>> rtl/time_indexed_log_directory.sv
// ============================================================================
// time_indexed_log_directory
// Sparse time index over an append-only record log with Q32.32 timecodes.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_valid / o_stall          i_req_type, i_timecode
//  result    out        o_valid / i_stall          o_status, o_position,
//                                                  o_record_count, o_dir_modified
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (base position)
//
// An append or a sync item passes the decode and response states from acceptance
// to its result. A lookup decodes, then runs the search probes (at most log2 of
// the fill), the walk check after a search, the walk or zero-skip steps, and a
// rounding by masking (power-of-two frame) or by reciprocal multiply. A compaction
// after the append that fills the directory moves the even slots to the lower half;
// reset is synchronous and active low; only filled slots, or slot 0 when empty, are read.
// The input is stalled while an item is worked on or a stalled result waits.
// ============================================================================
module time_indexed_log_directory #(
    parameter int DIR_ENTRIES = tld_pkg::DIR_ENTRIES_DEF,
    parameter int FRAME_BYTES = tld_pkg::FRAME_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [tld_pkg::REQ_W-1:0]       i_req_type,
    input  logic signed [tld_pkg::TC_W-1:0] i_timecode,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [tld_pkg::STS_W-1:0]       o_status,
    output logic [tld_pkg::POS_W-1:0]       o_position,
    output logic [tld_pkg::CNT_W-1:0]       o_record_count,
    output logic                            o_dir_modified,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tld_pkg::POS_W-1:0]       i_cfg_data
);

    tld_pkg::t_cmd cmd;
    tld_pkg::t_sts sts;
    logic          cfg_wr;

    // The base position register accepts a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // The controller walks each item through its states; the datapath holds
    // all bookkeeping, the directory RAM and the rounding unit.
    tld_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    tld_dp #(
        .DIR_ENTRIES(DIR_ENTRIES),
        .FRAME_BYTES(FRAME_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_timecode    (i_timecode),
        .i_cfg_valid   (cfg_wr),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_record_count(o_record_count),
        .o_dir_modified(o_dir_modified)
    );

endmodule

>>> rtl/tld_ram.sv
// ============================================================================
// tld_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tld_dp.sv
// ============================================================================
// tld_dp
// Datapath: bookkeeping registers, directory RAM, search index and rounding.
// ============================================================================
`include "time_indexed_log_directory_macros.svh"

module tld_dp #(
    parameter int DIR_ENTRIES = tld_pkg::DIR_ENTRIES_DEF,
    parameter int FRAME_BYTES = tld_pkg::FRAME_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tld_pkg::t_cmd                  i_cmd,
    output tld_pkg::t_sts                  o_sts,
    input  logic [tld_pkg::REQ_W-1:0]      i_req_type,
    input  logic signed [tld_pkg::TC_W-1:0] i_timecode,
    input  logic                           i_cfg_valid,
    input  logic [tld_pkg::POS_W-1:0]      i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tld_pkg::STS_W-1:0]      o_status,
    output logic [tld_pkg::POS_W-1:0]      o_position,
    output logic [tld_pkg::CNT_W-1:0]      o_record_count,
    output logic                           o_dir_modified
);

    localparam int TC_W   = tld_pkg::TC_W;
    localparam int POS_W  = tld_pkg::POS_W;
    localparam int CNT_W  = tld_pkg::CNT_W;
    localparam int STEP_W = tld_pkg::STEP_W;
    localparam int AW     = $clog2(DIR_ENTRIES);
    localparam int FW     = AW + 1;
    localparam int HALF   = DIR_ENTRIES / 2;
    localparam int RAM_W  = TC_W + POS_W;
    localparam bit POW2   = (FRAME_BYTES & (FRAME_BYTES - 1)) == 0;
    localparam logic [POS_W-1:0] FMASK     = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] FRAME_POS = POS_W'(FRAME_BYTES);

    // Reciprocal of the frame size, scaled so that the quotient estimate is
    // never more than one below the true quotient.
    localparam int MUL_S = POS_W + $clog2(FRAME_BYTES);
    localparam int MW    = POS_W + 1;
    localparam int MH    = (MW + 1) / 2;
    localparam int XH    = POS_W / 2;
    localparam int ACC_W = POS_W + MW;
    localparam logic [63:0]   RECIP_FULL = (64'd1 << MUL_S) / 64'(FRAME_BYTES);
    localparam logic [MW-1:0] RECIP      = MW'(RECIP_FULL);
    localparam int MS_W = 3;
    localparam logic [MS_W-1:0] MSTEP_QF   = 3'd4;
    localparam logic [MS_W-1:0] MSTEP_DONE = 3'd5;

    logic [tld_pkg::REQ_W-1:0] r_req;
    logic signed [TC_W-1:0]    r_tc;
    logic [POS_W-1:0]          r_base;
    logic [POS_W-1:0]          r_next;
    logic [CNT_W-1:0]          r_records;
    logic signed [TC_W-1:0]    r_first;
    logic signed [TC_W-1:0]    r_last;
    logic [STEP_W-1:0]         r_step;
    logic [STEP_W-1:0]         r_scount;
    logic [FW-1:0]             r_fill;
    logic                      r_mod;
    logic [AW-1:0]             r_cnt;
    logic [AW-1:0]             r_idx;
    logic [AW-1:0]             r_n;
    logic [POS_W-1:0]          r_pos;
    logic [ACC_W-1:0]          r_acc;
    logic [POS_W-1:0]          r_qf;
    logic [MS_W-1:0]           r_mstep;
    logic [tld_pkg::STS_W-1:0] r_status;
    logic                      r_out_valid;
    logic [tld_pkg::STS_W-1:0] r_out_status;
    logic [POS_W-1:0]          r_out_pos;
    logic [CNT_W-1:0]          r_out_cnt;
    logic                      r_out_mod;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [RAM_W-1:0]       ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [RAM_W-1:0]       ram_rdata;
    logic signed [TC_W-1:0] rd_time;
    logic [POS_W-1:0]       rd_pos;
    logic [POS_W-1:0]       pos_eff;
    logic [POS_W-1:0]       pos_hi;
    logic [POS_W-1:0]       pos_clamped;
    logic [POS_W-1:0]       pos_rounded;
    logic                   tc_lt_t;
    logic                   t_lt_tc;
    logic                   app_ok;
    logic [STEP_W-1:0]      scount_inc;
    logic                   sample;
    logic [AW-1:0]          n_half;
    logic [XH-1:0]          mul_a;
    logic [MH-1:0]          mul_b;
    logic [XH+MH-1:0]       mul_p;
    logic [ACC_W-1:0]       mul_term;
    logic [POS_W-1:0]       q_est;
    logic [POS_W-1:0]       qf_rem;

    tld_ram #(
        .WIDTH(RAM_W),
        .DEPTH(DIR_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_time = ram_rdata[RAM_W-1 -: TC_W];
    assign rd_pos  = ram_rdata[POS_W-1:0];
    assign tc_lt_t = r_tc < rd_time;
    assign t_lt_tc = rd_time < r_tc;

    assign app_ok     = !((r_records != '0) && (r_tc < r_last));
    assign scount_inc = r_scount + STEP_W'(1);
    assign sample     = scount_inc >= r_step;
    assign n_half     = r_n >> 1;

    // An empty directory holds no entry, so the position of its first slot is taken as zero.
    assign pos_eff     = (r_fill == '0) ? '0 : rd_pos;
    assign pos_hi      = (r_next < pos_eff) ? r_next : pos_eff;
    assign pos_clamped = (r_base > pos_hi) ? r_base : pos_hi;

    // Rounding by reciprocal multiplication: four half-width partial
    // products, one per cycle, then the quotient times the frame size, and a
    // single correction when the estimate fell one frame short.
    always_comb begin
        mul_a = r_mstep[1] ? r_pos[POS_W-1:XH] : r_pos[XH-1:0];
        mul_b = r_mstep[0] ? MH'(RECIP[MW-1:MH]) : RECIP[MH-1:0];
        mul_p = mul_a * mul_b;
        case (r_mstep[1:0])
            2'd0: begin
                mul_term = ACC_W'(mul_p);
            end
            2'd1: begin
                mul_term = ACC_W'(mul_p) << MH;
            end
            2'd2: begin
                mul_term = ACC_W'(mul_p) << XH;
            end
            default: begin
                mul_term = ACC_W'(mul_p) << (XH + MH);
            end
        endcase
    end

    assign q_est       = POS_W'(r_acc >> MUL_S);
    assign qf_rem      = r_pos - r_qf;
    assign pos_rounded = POW2 ? (r_pos & ~FMASK)
                       : ((qf_rem >= FRAME_POS) ? (r_qf + FRAME_POS) : r_qf);

    assign ram_we    = (i_cmd.do_append && app_ok && sample) || i_cmd.cp_wr;
    assign ram_waddr = i_cmd.cp_wr ? r_cnt : r_fill[AW-1:0];
    assign ram_wdata = i_cmd.cp_wr ? ram_rdata : {r_tc, r_next};
    assign ram_raddr = i_cmd.rd_copy ? AW'({r_cnt, 1'b0}) : r_idx;

    always_comb begin
        o_sts               = '0;
        o_sts.req           = r_req;
        o_sts.out_free      = !r_out_valid || !i_stall;
        o_sts.srch_trivial  = (r_records == '0) || (r_tc < r_first) || (r_fill < FW'(2));
        o_sts.srch_stop     = (!tc_lt_t && !t_lt_tc) || (n_half == '0);
        o_sts.idx_zero      = r_idx == '0;
        o_sts.tc_lt_t       = tc_lt_t;
        o_sts.pos_zero_more = (pos_eff == '0) && (r_idx != '0);
        o_sts.rem_done      = POW2 || (r_mstep == MSTEP_DONE);
        o_sts.compact       = r_fill == FW'(DIR_ENTRIES);
        o_sts.cp_last       = r_cnt == AW'(HALF - 1);
    end

    // Control state and architectural bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= tld_pkg::BASE_RESET;
            r_next      <= tld_pkg::BASE_RESET;
            r_records   <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_step      <= STEP_W'(1);
            r_scount    <= '0;
            r_fill      <= '0;
            r_mod       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.do_append && app_ok) begin
                if (r_records == '0) begin
                    r_first <= r_tc;
                end
                r_next    <= r_next + FRAME_POS;
                r_last    <= r_tc;
                r_records <= r_records + CNT_W'(1);
                r_scount  <= sample ? '0 : scount_inc;
                if (sample) begin
                    r_mod  <= 1'b1;
                    r_fill <= r_fill + FW'(1);
                end
            end else if (i_cfg_valid && (r_records == '0)) begin
                r_next <= i_cfg_data;
            end
            if (i_cmd.do_sync) begin
                r_mod <= 1'b0;
            end
            if (i_cmd.cp_end) begin
                r_cnt  <= '0;
                r_fill <= FW'(HALF);
                r_step <= r_step + STEP_W'(1);
            end else if (i_cmd.cp_wr) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload, search index and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_req <= i_req_type;
            r_tc  <= i_timecode;
        end
        if (i_cmd.do_append) begin
            r_pos    <= app_ok ? r_next : '0;
            r_status <= app_ok ? tld_pkg::ST_APPENDED : tld_pkg::ST_REJECTED;
        end
        if (i_cmd.do_sync) begin
            r_pos    <= '0;
            r_status <= tld_pkg::ST_SYNCED;
        end
        if (i_cmd.srch_init) begin
            r_n      <= AW'(r_fill >> 1);
            r_idx    <= AW'(r_fill >> 1);
            r_status <= tld_pkg::ST_LOOKUP;
        end
        if (i_cmd.idx_zero) begin
            r_idx    <= '0;
            r_status <= tld_pkg::ST_LOOKUP;
        end
        if (i_cmd.srch_step) begin
            r_n <= n_half;
            if (tc_lt_t) begin
                r_idx <= r_idx - n_half;
            end else if (t_lt_tc) begin
                r_idx <= r_idx + n_half;
            end
        end
        if (i_cmd.walk_dec) begin
            r_idx <= r_idx - AW'(1);
        end
        if (i_cmd.idx_clamp && ({1'b0, r_idx} >= r_fill)) begin
            r_idx <= (r_fill != '0) ? AW'(r_fill - FW'(1)) : '0;
        end
        if (i_cmd.pos_take) begin
            r_pos   <= pos_clamped;
            r_acc   <= '0;
            r_mstep <= '0;
        end
        if (i_cmd.rem_step) begin
            if (r_mstep == MSTEP_QF) begin
                r_qf <= q_est * FRAME_POS;
            end else begin
                r_acc <= r_acc + mul_term;
            end
            r_mstep <= r_mstep + MS_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_pos    <= i_cmd.out_round ? pos_rounded : r_pos;
            r_out_cnt    <= r_records;
            r_out_mod    <= r_mod;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_position     = r_out_pos;
    assign o_record_count = r_out_cnt;
    assign o_dir_modified = r_out_mod;

    `TLD_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(DIR_ENTRIES),
        "directory fill beyond its depth")
    `TLD_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load,
        !(r_out_valid && i_stall), "result loaded over a waiting result")

endmodule

>>> rtl/tld_ctrl.sv
// ============================================================================
// tld_ctrl
// Controller: sequences append, lookup, sync and directory compaction.
// ============================================================================
`include "time_indexed_log_directory_macros.svh"

module tld_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  tld_pkg::t_sts i_sts,
    output tld_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RESP, S_S_RD, S_S_CMP, S_W_RD, S_W_CMP,
        S_POS, S_P_RD, S_P_CMP, S_RND, S_CP_RD, S_CP_WR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    assign o_stall = !((r_state == S_IDLE) && i_sts.out_free);
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.req)
                    tld_pkg::REQ_APPEND: begin
                        o_cmd.do_append = 1'b1;
                        n_state         = S_RESP;
                    end
                    tld_pkg::REQ_LOOKUP: begin
                        if (i_sts.srch_trivial) begin
                            o_cmd.idx_zero = 1'b1;
                            n_state        = S_POS;
                        end else begin
                            o_cmd.srch_init = 1'b1;
                            n_state         = S_S_RD;
                        end
                    end
                    tld_pkg::REQ_SYNC: begin
                        o_cmd.do_sync = 1'b1;
                        n_state       = S_RESP;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RESP: begin
                o_cmd.out_load = 1'b1;
                n_state        = i_sts.compact ? S_CP_RD : S_IDLE;
            end
            S_S_RD: begin
                n_state = S_S_CMP;
            end
            S_S_CMP: begin
                o_cmd.srch_step = 1'b1;
                n_state         = i_sts.srch_stop ? S_W_RD : S_S_RD;
            end
            S_W_RD: begin
                n_state = i_sts.idx_zero ? S_POS : S_W_CMP;
            end
            S_W_CMP: begin
                if (i_sts.tc_lt_t) begin
                    o_cmd.walk_dec = 1'b1;
                    n_state        = S_W_RD;
                end else begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                o_cmd.idx_clamp = 1'b1;
                n_state         = S_P_RD;
            end
            S_P_RD: begin
                n_state = S_P_CMP;
            end
            S_P_CMP: begin
                if (i_sts.pos_zero_more) begin
                    o_cmd.walk_dec = 1'b1;
                    n_state        = S_P_RD;
                end else begin
                    o_cmd.pos_take = 1'b1;
                    n_state        = S_RND;
                end
            end
            S_RND: begin
                if (i_sts.rem_done) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_round = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.rem_step = 1'b1;
                end
            end
            S_CP_RD: begin
                o_cmd.rd_copy = 1'b1;
                n_state       = S_CP_WR;
            end
            S_CP_WR: begin
                o_cmd.cp_wr = 1'b1;
                if (i_sts.cp_last) begin
                    o_cmd.cp_end = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_CP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `TLD_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, in_acc, r_state == S_DECODE,
        "accepted item not decoded in the next cycle")

endmodule
